// ===== sv/tscb_pkg.sv =====
// Shared types, constants and helpers for the triangle slab clip bounding box unit.
`default_nettype none

package tscb_pkg;

  localparam int COORD_BITS = 32;
  localparam int NUM_VERT   = 3;
  localparam int NUM_CROSS  = 6;
  localparam int NUM_LANE   = 2 * NUM_CROSS;
  localparam int DIV_STEPS  = COORD_BITS;
  // multiply stage, one stage per quotient bit, round stage
  localparam int LANE_LAT   = DIV_STEPS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0] mag_t;
  typedef logic [COORD_BITS:0] wdiff_t;

  localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_Z_ALT = 2'd3;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    logic [1:0] axis;
    coord_t slab_low;
    coord_t slab_high;
  } in_req_t;

  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
    logic empty_res;
  } out_res_t;

  // operands of one interpolated coordinate
  typedef struct packed {
    coord_t po;
    logic neg;
    mag_t m1;
    mag_t m2;
    mag_t den;
  } lane_op_t;

  // signed difference a - b, one bit wider
  function automatic wdiff_t sub_wide(input coord_t a, input coord_t b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  function automatic mag_t mag_of(input wdiff_t x);
    wdiff_t n;
    n = x[COORD_BITS] ? (~x + wdiff_t'(1)) : x;
    return n[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/triangle_slab_clip_bbox_unit.sv =====
// Top level of the triangle slab clip bounding box unit.
// Takes one triangle per cycle unless the output stalls, and returns the bounding box of
// its part inside the slab [slab_low, slab_high] on the chosen axis (axis code 3 means z);
// an inverted or missed slab gives empty_res with min at the most positive and max at the
// most negative value. An item passes one operand stage, twelve interpolation lanes of a
// multiply stage, one restoring-divide stage per quotient bit and a round stage, then two
// min/max stages; the divide chain sets the depth. A stalled output freezes the whole
// pipeline.
`default_nettype none

module triangle_slab_clip_bbox_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  tscb_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tscb_pkg::out_res_t out_data
);

  localparam int CW  = tscb_pkg::COORD_BITS;
  localparam int NV  = tscb_pkg::NUM_VERT;
  localparam int NC  = tscb_pkg::NUM_CROSS;
  localparam int NL  = tscb_pkg::NUM_LANE;
  localparam int LAT = tscb_pkg::LANE_LAT;
  localparam int NP  = NV + NC;

  typedef struct packed {
    logic [NV-1:0][NV-1:0][CW-1:0] vert;
    logic [NV-1:0] vin;
    logic [NC-1:0] xing;
    logic [1:0][CW-1:0] plane;
    logic [1:0] d;
  } side_t;

  logic en;

  // operand stage
  tscb_pkg::coord_t   v [NV][NV];
  tscb_pkg::coord_t   pd [NV];
  logic [1:0]         d, o0, o1;
  logic               slab_ok;
  logic [NV-1:0]      ge, le;
  side_t              s1_side_nxt, s1_side_r;
  tscb_pkg::lane_op_t op_nxt [NL];
  tscb_pkg::lane_op_t op_r [NL];
  logic               s1_vld_r;

  tscb_pkg::coord_t   lane_res [NL];

  side_t              side_r [LAT];
  logic [LAT-1:0]     vld_r;

  // reduction
  tscb_pkg::coord_t   cp [NP][3];
  logic [NP-1:0]      cv;
  tscb_pkg::coord_t   gmin_nxt [3][3], gmax_nxt [3][3];
  tscb_pkg::coord_t   gmin_r [3][3], gmax_r [3][3];
  logic [2:0]         gval_nxt, gval_r;
  logic               r1_vld_r;
  tscb_pkg::out_res_t out_nxt, out_r;
  logic               out_vld_r;

  assign en       = !out_vld_r || !out_stall;
  assign in_stall = !en;

  always_comb begin
    v[0][0] = in_data.ax; v[0][1] = in_data.ay; v[0][2] = in_data.az;
    v[1][0] = in_data.bx; v[1][1] = in_data.by; v[1][2] = in_data.bz;
    v[2][0] = in_data.cx; v[2][1] = in_data.cy; v[2][2] = in_data.cz;
  end

  always_comb begin
    unique case (in_data.axis)
      tscb_pkg::AXIS_X: d = tscb_pkg::AXIS_X;
      tscb_pkg::AXIS_Y: d = tscb_pkg::AXIS_Y;
      tscb_pkg::AXIS_Z, tscb_pkg::AXIS_Z_ALT: d = tscb_pkg::AXIS_Z;
      default: d = tscb_pkg::AXIS_Z;
    endcase
    o0 = (d == tscb_pkg::AXIS_X) ? tscb_pkg::AXIS_Y : tscb_pkg::AXIS_X;
    o1 = (d == tscb_pkg::AXIS_Z) ? tscb_pkg::AXIS_Y : tscb_pkg::AXIS_Z;
  end

  always_comb begin
    tscb_pkg::coord_t po, qo, s;
    tscb_pkg::wdiff_t dpo, dsp, dqp;
    logic [1:0] k;
    int j, c, l;
    slab_ok = $signed(in_data.slab_low) <= $signed(in_data.slab_high);
    s1_side_nxt = '0;
    for (int i = 0; i < NV; i++) begin
      pd[i] = v[i][d];
      ge[i] = $signed(pd[i]) >= $signed(in_data.slab_low);
      le[i] = $signed(pd[i]) <= $signed(in_data.slab_high);
      s1_side_nxt.vin[i] = slab_ok && ge[i] && le[i];
      for (int kk = 0; kk < NV; kk++) begin
        s1_side_nxt.vert[i][kk] = v[i][kk];
      end
    end
    s1_side_nxt.plane[0] = in_data.slab_low;
    s1_side_nxt.plane[1] = in_data.slab_high;
    s1_side_nxt.d = d;
    for (int i = 0; i < NV; i++) begin
      j = (i == NV - 1) ? 0 : i + 1;
      for (int pl = 0; pl < 2; pl++) begin
        c = 2 * i + pl;
        s = (pl == 1) ? in_data.slab_high : in_data.slab_low;
        s1_side_nxt.xing[c] = slab_ok && ((pl == 1) ? (le[i] != le[j]) : (ge[i] != ge[j]));
        for (int t = 0; t < 2; t++) begin
          l = 2 * c + t;
          k = (t == 1) ? o1 : o0;
          po = v[i][k];
          qo = v[j][k];
          dpo = tscb_pkg::sub_wide(qo, po);
          dsp = tscb_pkg::sub_wide(s, pd[i]);
          dqp = tscb_pkg::sub_wide(pd[j], pd[i]);
          op_nxt[l].po  = po;
          op_nxt[l].neg = dpo[CW] ^ dsp[CW] ^ dqp[CW];
          op_nxt[l].m1  = tscb_pkg::mag_of(dpo);
          op_nxt[l].m2  = tscb_pkg::mag_of(dsp);
          op_nxt[l].den = tscb_pkg::mag_of(dqp);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      vld_r     <= '0;
      r1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_valid;
      vld_r     <= {vld_r[LAT-2:0], s1_vld_r};
      r1_vld_r  <= vld_r[LAT-1];
      out_vld_r <= r1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_side_nxt;
      op_r      <= op_nxt;
      side_r[0] <= s1_side_r;
      for (int n = 1; n < LAT; n++) begin
        side_r[n] <= side_r[n-1];
      end
    end
  end

  for (genvar gl = 0; gl < NL; gl++) begin : g_lane
    tscb_interp_lane u_lane (
      .clk (clk),
      .en  (en),
      .op  (op_r[gl]),
      .res (lane_res[gl])
    );
  end

  // gather vertices and crossing points, then reduce in two levels
  always_comb begin
    side_t sd;
    logic [1:0] q0;
    sd = side_r[LAT-1];
    q0 = (sd.d == tscb_pkg::AXIS_X) ? tscb_pkg::AXIS_Y : tscb_pkg::AXIS_X;
    for (int n = 0; n < NV; n++) begin
      cv[n] = sd.vin[n];
      for (int k = 0; k < 3; k++) begin
        cp[n][k] = sd.vert[n][k];
      end
    end
    for (int c = 0; c < NC; c++) begin
      cv[NV+c] = sd.xing[c];
      for (int k = 0; k < 3; k++) begin
        if (sd.d == 2'(k)) begin
          cp[NV+c][k] = sd.plane[c % 2];
        end else if (q0 == 2'(k)) begin
          cp[NV+c][k] = lane_res[2*c];
        end else begin
          cp[NV+c][k] = lane_res[2*c+1];
        end
      end
    end
  end

  always_comb begin
    logic val;
    for (int g = 0; g < 3; g++) begin
      val = 1'b0;
      for (int k = 0; k < 3; k++) begin
        gmin_nxt[g][k] = tscb_pkg::COORD_MAX;
        gmax_nxt[g][k] = tscb_pkg::COORD_MIN;
      end
      for (int n = 3 * g; n < 3 * g + 3; n++) begin
        if (cv[n]) begin
          for (int k = 0; k < 3; k++) begin
            if (!val || $signed(cp[n][k]) < $signed(gmin_nxt[g][k])) gmin_nxt[g][k] = cp[n][k];
            if (!val || $signed(cp[n][k]) > $signed(gmax_nxt[g][k])) gmax_nxt[g][k] = cp[n][k];
          end
          val = 1'b1;
        end
      end
      gval_nxt[g] = val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gmin_r <= gmin_nxt;
      gmax_r <= gmax_nxt;
      gval_r <= gval_nxt;
    end
  end

  always_comb begin
    tscb_pkg::coord_t mn [3], mx [3];
    logic val;
    val = 1'b0;
    for (int k = 0; k < 3; k++) begin
      mn[k] = tscb_pkg::COORD_MAX;
      mx[k] = tscb_pkg::COORD_MIN;
    end
    for (int g = 0; g < 3; g++) begin
      if (gval_r[g]) begin
        for (int k = 0; k < 3; k++) begin
          if (!val || $signed(gmin_r[g][k]) < $signed(mn[k])) mn[k] = gmin_r[g][k];
          if (!val || $signed(gmax_r[g][k]) > $signed(mx[k])) mx[k] = gmax_r[g][k];
        end
        val = 1'b1;
      end
    end
    out_nxt.box_min_x = mn[0];
    out_nxt.box_min_y = mn[1];
    out_nxt.box_min_z = mn[2];
    out_nxt.box_max_x = mx[0];
    out_nxt.box_max_y = mx[1];
    out_nxt.box_max_z = mx[2];
    out_nxt.empty_res = !val;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.empty_res |->
      $signed(out_r.box_min_x) <= $signed(out_r.box_max_x) &&
      $signed(out_r.box_min_y) <= $signed(out_r.box_max_y) &&
      $signed(out_r.box_min_z) <= $signed(out_r.box_max_z))
    else $error("nonempty box has min above max");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r && $stable(out_r))
    else $error("stalled result changed");

  a_pipe_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(r1_vld_r) && $stable(s1_vld_r))
    else $error("pipeline advanced during stall");

endmodule

`default_nettype wire

// ===== sv/tscb_interp_lane.sv =====
// Pipelined interpolation lane: multiply, restoring divide one bit per stage, round and offset.
`default_nettype none

module tscb_interp_lane (
  input  wire logic              clk,
  input  wire logic              en,
  input  tscb_pkg::lane_op_t     op,
  output tscb_pkg::coord_t       res
);

  localparam int CW = tscb_pkg::COORD_BITS;
  localparam int NS = tscb_pkg::DIV_STEPS;

  logic [2*CW-1:0] prod_r, prod_nxt;
  tscb_pkg::mag_t   den_m_r;
  tscb_pkg::coord_t po_m_r;
  logic             neg_m_r;

  tscb_pkg::mag_t   rem_r [NS];
  tscb_pkg::mag_t   lq_r  [NS];
  tscb_pkg::mag_t   den_r [NS];
  tscb_pkg::coord_t po_r  [NS];
  logic             neg_r [NS];

  tscb_pkg::mag_t   rem_src [NS];
  tscb_pkg::mag_t   lq_src  [NS];
  tscb_pkg::mag_t   den_src [NS];
  tscb_pkg::coord_t po_src  [NS];
  logic             neg_src [NS];

  tscb_pkg::coord_t res_r, res_nxt;
  tscb_pkg::mag_t   quot;
  logic             round_up;

  assign prod_nxt = (2*CW)'(op.m1) * (2*CW)'(op.m2);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      den_m_r <= op.den;
      po_m_r  <= op.po;
      neg_m_r <= op.neg;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_step
    logic [CW:0] trial, trial_sub;
    logic        fits;
    tscb_pkg::mag_t rem_nxt, lq_nxt;

    if (g == 0) begin : g_first
      // upper half of the product is below the divisor for a real crossing
      assign rem_src[g] = prod_r[2*CW-1:CW];
      assign lq_src[g]  = prod_r[CW-1:0];
      assign den_src[g] = den_m_r;
      assign po_src[g]  = po_m_r;
      assign neg_src[g] = neg_m_r;
    end else begin : g_next
      assign rem_src[g] = rem_r[g-1];
      assign lq_src[g]  = lq_r[g-1];
      assign den_src[g] = den_r[g-1];
      assign po_src[g]  = po_r[g-1];
      assign neg_src[g] = neg_r[g-1];
    end

    assign trial     = {rem_src[g], lq_src[g][CW-1]};
    assign trial_sub = trial - {1'b0, den_src[g]};
    assign fits      = trial >= {1'b0, den_src[g]};
    assign rem_nxt   = fits ? trial_sub[CW-1:0] : trial[CW-1:0];
    assign lq_nxt    = {lq_src[g][CW-2:0], fits};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        lq_r[g]  <= lq_nxt;
        den_r[g] <= den_src[g];
        po_r[g]  <= po_src[g];
        neg_r[g] <= neg_src[g];
      end
    end
  end

  // round half away from zero on the magnitude, then step from the first vertex
  assign round_up = {rem_r[NS-1], 1'b0} >= {1'b0, den_r[NS-1]};
  assign quot     = lq_r[NS-1] + tscb_pkg::mag_t'(round_up);
  assign res_nxt  = neg_r[NS-1] ? tscb_pkg::coord_t'(po_r[NS-1] - quot)
                                : tscb_pkg::coord_t'(po_r[NS-1] + quot);

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire
